FILE: hw/rtl/modular_exponentiation_unit_macros.svh
// ----------------------------------------------------------------------------
// Modular exponentiation unit assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

`ifndef SYNTH

`define MEU_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("meu assertion failed");

`define MEU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("meu implication failed");

`else

`define MEU_ASSERT(lbl, expr)

`define MEU_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/meu_pkg.sv
// ----------------------------------------------------------------------------
// meu_pkg
// Shared constants and types of the modular exponentiation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package meu_pkg;

  localparam int FIELD_W   = 32;  // width of modulus, exponent, base, result fields
  localparam int WIDTH_DEF = 32;  // default datapath width
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

  localparam logic [FIELD_W-1:0] MODULUS_RST  = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] EXPONENT_RST = FIELD_W'(1);

  // multiplier status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

FILE: hw/rtl/meu_mulmod.sv
// ----------------------------------------------------------------------------
// meu_mulmod
// Bit-serial interleaved modular multiplier, MSB of y first, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meu_mulmod #(
  parameter int WIDTH = meu_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WIDTH-1:0]    op_x,     // must be below modulus
  input  logic [WIDTH-1:0]    op_y,     // any value, only its bits are used
  input  logic [WIDTH-1:0]    modulus,  // held stable while busy
  output logic [WIDTH-1:0]    product,
  output meu_pkg::mm_status_t status
);
  import meu_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] acc_r;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH-1:0] acc_step;

  // acc < m and x < m, so 2*acc + x < 3m: subtract m or 2m at most
  always_comb begin
    m1  = (WIDTH+2)'(modulus);
    m2  = (WIDTH+2)'({modulus, 1'b0});
    sum = (WIDTH+2)'({acc_r, 1'b0}) + (y_r[WIDTH-1] ? (WIDTH+2)'(x_r) : '0);
    if (sum >= m2) begin
      acc_step = WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_step = WIDTH'(sum - m1);
    end else begin
      acc_step = WIDTH'(sum);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= op_x;
      y_r   <= op_y;
      acc_r <= '0;
    end else if (busy_r) begin
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
      acc_r <= acc_step;
    end
  end

  assign product     = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

FILE: hw/rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Each input beat carries one base; one output beat returns base^exponent mod
// modulus. Modulus and exponent are written over the cfg port (index 0 and 1)
// and are sampled when a base is taken, so they apply to the next beat on.
// All products go through one bit-serial modular multiplier that handles one
// multiplier bit per clock. An item takes one multiplier pass to reduce the
// base, then one square per exponent bit up to the top set bit (the last
// square is skipped) and one multiply per set bit, with one pass through
// S_STEP per exponent bit and a handoff through S_DONE to the output
// register. Exponent zero returns 1 mod modulus, modulus zero returns 0. A
// stalled result beat holds the sequencer in S_DONE until the output register
// is free. One item is in flight at a time; a finished result sits in the
// output register while the next base is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit #(
  parameter int WIDTH = meu_pkg::WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [meu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [meu_pkg::FIELD_W-1:0]     cfg_data,
  // base stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [meu_pkg::FIELD_W-1:0]     in_tdata,   // [31:0] base_value
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [meu_pkg::FIELD_W-1:0]     out_tdata   // [31:0] power_result
);
  import meu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,  // sq = base mod m
    S_STEP   = 6'b000100,  // look at next exponent bit
    S_MUL    = 6'b001000,  // res = res * sq
    S_SQR    = 6'b010000,  // sq = sq * sq
    S_DONE   = 6'b100000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [FIELD_W-1:0] modulus_r;
  logic [FIELD_W-1:0] exponent_r;

  // working registers
  logic [WIDTH-1:0]   m_r;
  logic [WIDTH-1:0]   e_r, e_nxt;
  logic [WIDTH-1:0]   res_r, res_nxt;
  logic [WIDTH-1:0]   sq_r, sq_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r;
  logic               out_load;

  // datapath view of config and input
  logic [WIDTH-1:0]   m_w;
  logic [WIDTH-1:0]   e_w;
  logic [WIDTH-1:0]   one_mod;
  logic               in_fire;

  // multiplier hookup
  logic               mm_start;
  logic [WIDTH-1:0]   mm_x;
  logic [WIDTH-1:0]   mm_y;
  logic [WIDTH-1:0]   mm_prod;
  mm_status_t         mm_status;

  assign m_w     = WIDTH'(modulus_r);
  assign e_w     = WIDTH'(exponent_r);
  assign one_mod = (m_w == WIDTH'(1)) ? '0 : WIDTH'(1);

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MODULUS_RST;
      exponent_r <= EXPONENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_data;
        REG_EXPONENT: exponent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    res_nxt   = res_r;
    sq_nxt    = sq_r;
    mm_start  = 1'b0;
    mm_x      = sq_r;
    mm_y      = sq_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          e_nxt   = e_w;
          res_nxt = one_mod;
          if (m_w == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // x = 1 mod m turns the multiplier into a serial remainder of y
            mm_start  = 1'b1;
            mm_x      = one_mod;
            mm_y      = WIDTH'(in_tdata);
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mm_status.done) begin
          sq_nxt    = mm_prod;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          state_nxt = S_DONE;
        end else if (e_r[0]) begin
          mm_start  = 1'b1;
          mm_x      = res_r;
          state_nxt = S_MUL;
        end else begin
          mm_start  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_status.done) begin
          res_nxt = mm_prod;
          if ((e_r >> 1) == '0) begin
            state_nxt = S_DONE;  // no higher bits: skip the final square
          end else begin
            mm_start  = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_status.done) begin
          sq_nxt    = mm_prod;
          e_nxt     = e_r >> 1;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    res_r <= res_nxt;
    sq_r  <= sq_nxt;
    if (in_fire) begin
      m_r <= m_w;
    end
    if (out_load) begin
      out_data_r <= FIELD_W'(res_r);
    end
  end

  meu_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_x    (mm_x),
    .op_y    (mm_y),
    .modulus (m_r),
    .product (mm_prod),
    .status  (mm_status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `MEU_ASSERT(a_state_onehot, $onehot(state_r))
  `MEU_ASSERT_IMPL(a_idle_mul_quiet, state_r == S_IDLE, !mm_status.busy && !mm_status.done)
  `MEU_ASSERT_IMPL(a_done_in_mul_state, mm_status.done,
    state_r == S_REDUCE || state_r == S_MUL || state_r == S_SQR)
  `MEU_ASSERT_IMPL(a_operands_reduced, state_r == S_STEP, res_r < m_r && sq_r < m_r)

endmodule
